>>> rtl/core/pfoc_pkg.sv
// ----------------------------------------------------------------------------
// pfoc_pkg
// Shared types and constants of the panel fade overlay compositor.
// ----------------------------------------------------------------------------
package pfoc_pkg;

  localparam int PANELS_IN_STAGE = 9;
  localparam int LEDS_IN_PANEL   = 16;

  typedef enum logic [1:0] {
    OP_SET_LIGHT   = 2'd0,
    OP_SET_OVERLAY = 2'd1,
    OP_FADE        = 2'd2,
    OP_RENDER      = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    CFG_FADE_ON_STEP  = 3'd0,
    CFG_FADE_OFF_STEP = 3'd1,
    CFG_OVERLAY_RED   = 3'd2,
    CFG_OVERLAY_GREEN = 3'd3,
    CFG_OVERLAY_BLUE  = 3'd4
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_CALC_START,
    ST_CALC_WAIT,
    ST_EMIT
  } seq_state_t;

  typedef enum logic [3:0] {
    MU_IDLE,
    MU_M0,
    MU_M1,
    MU_M2,
    MU_M3,
    MU_M4,
    MU_SAT,
    MU_DIV,
    MU_DONE
  } mix_state_t;

  typedef struct packed {
    logic [23:0] color;
    logic        back_on;
    logic [7:0]  back_alpha;
    logic        front_on;
    logic [7:0]  front_alpha;
  } panel_entry_t;

  typedef struct packed {
    logic [7:0] cf;
    logic [7:0] cb;
    logic [7:0] fa;
    logic [7:0] ba;
    logic [7:0] on_step;
    logic [7:0] off_step;
  } mix_req_t;

  typedef struct packed {
    logic [7:0] plain;
    logic [7:0] blend;
  } mix_res_t;

endpackage

>>> rtl/core/pfoc_ram.sv
// ----------------------------------------------------------------------------
// pfoc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfoc_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/pfoc_mix_unit.sv
// ----------------------------------------------------------------------------
// pfoc_mix_unit
// Computes one color channel of a panel: the plain background value and the
// alpha-over blend, with one shared 16x8 multiplier and a restoring divider.
// ----------------------------------------------------------------------------
module pfoc_mix_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  pfoc_pkg::mix_req_t req,
  output logic               done,
  output pfoc_pkg::mix_res_t res
);
  import pfoc_pkg::*;

  mix_state_t  state, state_next;
  logic [15:0] mul_a;
  logic [7:0]  mul_b;
  logic [23:0] prod;
  logic [7:0]  ra, ub, ff, q;
  logic [15:0] pb, pf, den;
  logic [25:0] num;
  logic [22:0] dsh;
  logic [2:0]  cnt;
  logic        ge;

  // Exact floor(x / 255) for x up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  assign ge = (num >= 26'(dsh));

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      MU_IDLE: if (start) state_next = MU_M0;
      MU_M0: begin
        mul_a      = {8'h00, ~req.ba};
        mul_b      = ~req.fa;
        state_next = MU_M1;
      end
      MU_M1: begin
        mul_a      = {8'h00, req.cb};
        mul_b      = req.ba;
        state_next = MU_M2;
      end
      MU_M2: begin
        mul_a      = {8'h00, req.cf};
        mul_b      = req.fa;
        state_next = MU_M3;
      end
      MU_M3: begin
        mul_a      = pb;
        mul_b      = ~req.fa;
        state_next = MU_M4;
      end
      MU_M4: state_next = MU_SAT;
      MU_SAT: begin
        if (ra == 8'h00 || num >= 26'({den, 8'h00})) begin
          state_next = MU_DONE;
        end else begin
          state_next = MU_DIV;
        end
      end
      MU_DIV: if (cnt == 3'd0) state_next = MU_DONE;
      MU_DONE: state_next = MU_IDLE;
      default: state_next = MU_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MU_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    prod <= 24'(mul_a) * 24'(mul_b);
    case (state)
      MU_M1: ra <= 8'hFF - div255(prod[15:0]);
      MU_M2: begin
        ub <= div255(prod[15:0]);
        pb <= prod[15:0];
      end
      MU_M3: begin
        ff <= div255(prod[15:0]);
        pf <= prod[15:0];
      end
      MU_M4: begin
        num <= 26'({pf, 8'h00}) - 26'(pf) + 26'(prod);
        den <= {ra, 8'h00} - {8'h00, ra};
      end
      MU_SAT: begin
        dsh <= {den, 7'b0};
        cnt <= 3'd7;
        if (ra == 8'h00) begin
          q <= 8'h00;
        end else if (num >= 26'({den, 8'h00})) begin
          q <= 8'hFF;
        end else begin
          q <= 8'h00;
        end
      end
      MU_DIV: begin
        if (ge) begin
          num <= num - 26'(dsh);
        end
        q   <= {q[6:0], ge};
        dsh <= dsh >> 1;
        cnt <= cnt - 3'd1;
      end
      default: ;
    endcase
  end

  assign done      = (state == MU_DONE);
  assign res.plain = ub;
  assign res.blend = (ra < req.off_step) ? 8'h00 :
                     (req.fa < req.on_step) ? ub :
                     (req.ba < req.on_step) ? ff : q;

`ifndef SYNTH
  a_start_idle : assert property (@(posedge clk) disable iff (rst)
    start |-> state == MU_IDLE) else $error("mix unit started while busy");
  a_done_once : assert property (@(posedge clk) disable iff (rst)
    done |=> state == MU_IDLE) else $error("mix unit done not followed by idle");
  a_rem_bound : assert property (@(posedge clk) disable iff (rst)
    state == MU_DIV |-> num < 26'({den, 8'h00})) else $error("divider remainder out of range");
`endif

endmodule

>>> rtl/core/panel_fade_overlay_compositor.sv
// ----------------------------------------------------------------------------
// panel_fade_overlay_compositor
// Per-panel background and overlay state with fading and alpha-over render.
// Set light writes one panel entry, and its partner in the next stage when mirrored;
// set overlay and fade tick sweep every panel entry, one read-modify-write each.
// Render runs the shared mix unit once per color channel, then emits
// 16 items at one per cycle when result_ready stays high; one item at a time.
// After reset the panel memory is cleared.
// ----------------------------------------------------------------------------
module panel_fade_overlay_compositor #(
  parameter int STAGE_COUNT = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [1:0] opcode,
  input  logic [4:0] panel,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic       on_flag,
  input  logic       repeat_both,
  input  logic       snap_alpha,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [4:0] out_panel,
  output logic [3:0] led_index,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic       last
);
  import pfoc_pkg::*;

  localparam int PANEL_TOTAL = PANELS_IN_STAGE * STAGE_COUNT;
  localparam int AW          = $clog2(PANEL_TOTAL);

  // Configuration registers.
  logic [7:0] fade_on_step, fade_off_step, overlay_red, overlay_green, overlay_blue;

  // Sequencer state and the latched item.
  seq_state_t   state, state_next;
  logic [AW-1:0] addr;
  logic          first;
  opcode_t       op;
  logic [4:0]    p;
  logic [23:0]   rgb;
  logic          on, both, nofade;
  panel_entry_t  ent;
  logic [1:0]    chan;
  logic [3:0]    led;
  logic [7:0]    res_plain [3];
  logic [7:0]    res_blend [3];
  logic          pos0, pos2, pos6, pos8;

  // Memory port signals.
  logic          ram_we;
  panel_entry_t  ram_wdata, ram_rdata;

  // Mix unit.
  logic      mix_start, mix_done;
  mix_req_t  mix_req;
  mix_res_t  mix_res;

  logic item_acc, mirror, sweep_end, masked, in_range;

  function automatic logic [7:0] fade_one(input logic [7:0] a, input logic up,
                                          input logic [7:0] inc, input logic [7:0] dec);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, inc};
    if (up) begin
      return s[8] ? 8'hFF : s[7:0];
    end
    return (a < dec) ? 8'h00 : a - dec;
  endfunction

  // Position of a panel within its stage, by subtracting one stage per step.
  function automatic logic [3:0] stage_pos(input logic [4:0] v);
    logic [5:0] t;
    t = {1'b0, v};
    for (int k = 0; k < STAGE_COUNT; k++) begin
      if (t >= 6'(PANELS_IN_STAGE)) begin
        t = t - 6'(PANELS_IN_STAGE);
      end
    end
    return t[3:0];
  endfunction

  pfoc_ram #(
    .WIDTH ($bits(panel_entry_t)),
    .DEPTH (PANEL_TOTAL)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  pfoc_mix_unit u_mix (
    .clk   (clk),
    .rst   (rst),
    .start (mix_start),
    .req   (mix_req),
    .done  (mix_done),
    .res   (mix_res)
  );

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_on_step  <= 8'd16;
      fade_off_step <= 8'd16;
      overlay_red   <= 8'd0;
      overlay_green <= 8'd0;
      overlay_blue  <= 8'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FADE_ON_STEP:  fade_on_step  <= cfg_data;
        CFG_FADE_OFF_STEP: fade_off_step <= cfg_data;
        CFG_OVERLAY_RED:   overlay_red   <= cfg_data;
        CFG_OVERLAY_GREEN: overlay_green <= cfg_data;
        CFG_OVERLAY_BLUE:  overlay_blue  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign item_acc  = item_valid && item_ready;
  assign in_range  = (32'(panel) < PANEL_TOTAL);
  // The mirror write only applies to a first-stage panel whose partner exists.
  assign mirror    = first && both && (32'(p) < PANELS_IN_STAGE) &&
                     (32'(p) + PANELS_IN_STAGE < PANEL_TOTAL);
  assign sweep_end = (addr == AW'(PANEL_TOTAL - 1));

  // The mix request picks one color channel at a time.
  always_comb begin
    mix_req.fa       = ent.front_alpha;
    mix_req.ba       = ent.back_alpha;
    mix_req.on_step  = fade_on_step;
    mix_req.off_step = fade_off_step;
    case (chan)
      2'd0: begin
        mix_req.cf = overlay_red;
        mix_req.cb = ent.color[23:16];
      end
      2'd1: begin
        mix_req.cf = overlay_green;
        mix_req.cb = ent.color[15:8];
      end
      default: begin
        mix_req.cf = overlay_blue;
        mix_req.cb = ent.color[7:0];
      end
    endcase
  end

  // Next state, memory write and handshake outputs.
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_wdata  = ram_rdata;
    mix_start  = 1'b0;
    item_ready = 1'b0;
    result_valid = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (sweep_end) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          if ((opcode_t'(opcode) == OP_SET_LIGHT || opcode_t'(opcode) == OP_RENDER) &&
              !in_range) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ: state_next = ST_MODIFY;
      ST_MODIFY: begin
        case (op)
          OP_SET_LIGHT: begin
            ram_we = 1'b1;
            if (on) ram_wdata.color = rgb;
            ram_wdata.back_on = on;
            if (nofade) ram_wdata.back_alpha = on ? 8'hFF : 8'h00;
            state_next = mirror ? ST_READ : ST_IDLE;
          end
          OP_SET_OVERLAY: begin
            ram_we = 1'b1;
            ram_wdata.front_on = on;
            state_next = sweep_end ? ST_IDLE : ST_READ;
          end
          OP_FADE: begin
            ram_we = 1'b1;
            ram_wdata.front_alpha = fade_one(ram_rdata.front_alpha, ram_rdata.front_on,
                                             fade_on_step, fade_off_step);
            ram_wdata.back_alpha  = fade_one(ram_rdata.back_alpha, ram_rdata.back_on,
                                             fade_on_step, fade_off_step);
            state_next = sweep_end ? ST_IDLE : ST_READ;
          end
          default: state_next = ST_CALC_START;
        endcase
      end
      ST_CALC_START: begin
        mix_start  = 1'b1;
        state_next = ST_CALC_WAIT;
      end
      ST_CALC_WAIT: begin
        if (mix_done) state_next = (chan == 2'd2) ? ST_EMIT : ST_CALC_START;
      end
      ST_EMIT: begin
        result_valid = 1'b1;
        if (result_ready && led == 4'(LEDS_IN_PANEL - 1)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      addr  <= '0;
      first <= 1'b0;
      chan  <= '0;
      led   <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: addr <= addr + AW'(1);
        ST_IDLE: begin
          if (item_acc) begin
            first <= 1'b1;
            if (opcode_t'(opcode) == OP_SET_OVERLAY || opcode_t'(opcode) == OP_FADE) begin
              addr <= '0;
            end else begin
              addr <= AW'(panel);
            end
          end
        end
        ST_MODIFY: begin
          chan <= '0;
          if (op == OP_SET_LIGHT) begin
            first <= 1'b0;
            addr  <= AW'(32'(p) + PANELS_IN_STAGE);
          end else begin
            addr <= addr + AW'(1);
          end
        end
        ST_CALC_WAIT: begin
          if (mix_done) begin
            chan <= chan + 2'd1;
            led  <= '0;
          end
        end
        ST_EMIT: if (result_ready) led <= led + 4'd1;
        default: ;
      endcase
    end
  end

  // Item fields and render working values need no reset.
  always_ff @(posedge clk) begin
    if (item_acc) begin
      op     <= opcode_t'(opcode);
      p      <= panel;
      rgb    <= {red, green, blue};
      on     <= on_flag;
      both   <= repeat_both;
      nofade <= snap_alpha;
    end
    if (state == ST_MODIFY && op == OP_RENDER) begin
      ent  <= ram_rdata;
      pos0 <= (stage_pos(p) == 4'd0);
      pos2 <= (stage_pos(p) == 4'd2);
      pos6 <= (stage_pos(p) == 4'd6);
      pos8 <= (stage_pos(p) == 4'd8);
    end
    if (state == ST_CALC_WAIT && mix_done) begin
      res_plain[chan] <= mix_res.plain;
      res_blend[chan] <= mix_res.blend;
    end
  end

  // Border mask of the corner panels: outer row or column facing the edge.
  assign masked = ((pos0 || pos2) && led[3:2] == 2'd0) ||
                  ((pos6 || pos8) && led[3:2] == 2'd3) ||
                  ((pos0 || pos6) && led[1:0] == 2'd0) ||
                  ((pos2 || pos8) && led[1:0] == 2'd3);

  assign out_panel = p;
  assign led_index = led;
  assign out_red   = masked ? res_blend[0] : res_plain[0];
  assign out_green = masked ? res_blend[1] : res_plain[1];
  assign out_blue  = masked ? res_blend[2] : res_plain[2];
  assign last      = (led == 4'(LEDS_IN_PANEL - 1));

`ifndef SYNTH
  a_no_overlap : assert property (@(posedge clk) disable iff (rst)
    !(item_ready && result_valid)) else $error("item taken while results pending");
  a_last_frees : assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && last |=> item_ready)
    else $error("block not ready after final LED");
  a_write_phase : assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLEAR || state == ST_MODIFY))
    else $error("panel memory written outside an update step");
  a_mix_wait : assert property (@(posedge clk) disable iff (rst)
    mix_done |-> state == ST_CALC_WAIT) else $error("mix result arrived unexpectedly");
`endif

endmodule
